[rtl/core/gsp_pkg.sv]
// Shared types and constants for the grid shortest-path search block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none
package gsp_pkg;
	localparam int MAX_SIDE  = 64;
	localparam int SIDE_W    = $clog2(MAX_SIDE);
	localparam int CELLS     = MAX_SIDE * MAX_SIDE;
	localparam int CELL_AW   = $clog2(CELLS);
	localparam int LEN_W     = 12;
	localparam int IDX_W     = 12;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_PLAN = 2'd1,
		REQ_READ = 2'd2,
		REQ_NOP  = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_NO_PATH  = 2'd1,
		STS_OFF_GRID = 2'd2,
		STS_BEYOND   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RD_WAIT, S_PLAN_CHK, S_VIS_CLR, S_INIT, S_POP, S_POP_WAIT,
		S_NBR, S_NBR_CHK, S_CNT, S_CNT_WAIT, S_FILL, S_FILL_WAIT
	} state_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [SIDE_W-1:0] cell_x;
		logic [SIDE_W-1:0] cell_y;
		logic              cell_free;
		logic [SIDE_W-1:0] start_x;
		logic [SIDE_W-1:0] start_y;
		logic [SIDE_W-1:0] goal_x;
		logic [SIDE_W-1:0] goal_y;
		logic [IDX_W-1:0]  step_index;
	} req_t;

	typedef struct packed {
		logic    clr_wr;
		logic    clr_free;
		logic    accept;
		logic    accept_plan;
		logic    load_wr;
		logic    out_load;
		logic    out_read;
		status_t out_code;
		logic    set_count;
		logic    init_start;
		logic    pop_issue;
		logic    pop_take;
		logic    nbr_mark;
		logic    d_inc;
		logic    tr_init;
		logic    cnt_step;
		logic    fill_init;
		logic    fill_step;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
		logic clr_last;
		logic start_off;
		logic goal_off;
		logic head_lt_tail;
		logic cur_is_goal;
		logic cur_is_start;
		logic nbr_ok;
		logic d_last;
		logic k_zero;
	} sts_t;
endpackage
`default_nettype wire

[rtl/core/gsp_if.sv]
// Request and response channel interfaces (valid/ready plus payload).
// Depends on gsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface gsp_req_if;
	import gsp_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [SIDE_W-1:0] cell_x;
	logic [SIDE_W-1:0] cell_y;
	logic              cell_free;
	logic [SIDE_W-1:0] start_x;
	logic [SIDE_W-1:0] start_y;
	logic [SIDE_W-1:0] goal_x;
	logic [SIDE_W-1:0] goal_y;
	logic [IDX_W-1:0]  step_index;
	modport source (output valid, req_type, cell_x, cell_y, cell_free, start_x, start_y,
		goal_x, goal_y, step_index, input ready);
	modport sink (input valid, req_type, cell_x, cell_y, cell_free, start_x, start_y,
		goal_x, goal_y, step_index, output ready);
endinterface

interface gsp_rsp_if;
	import gsp_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [LEN_W-1:0]  path_length;
	logic [SIDE_W-1:0] step_x;
	logic [SIDE_W-1:0] step_y;
	modport source (output valid, status, path_length, step_x, step_y, input ready);
	modport sink (input valid, status, path_length, step_x, step_y, output ready);
endinterface
`default_nettype wire

[rtl/core/gsp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gsp_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[rtl/core/gsp_ctrl.sv]
// Sequencer for map load, path read and the breadth-first plan.
// Depends on gsp_pkg; drives gsp_dp through cmd_t, watches sts_t.
`timescale 1ns / 1ps
`default_nettype none
module gsp_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic [1:0]    req_type,
	output logic               req_ready,
	input  wire gsp_pkg::sts_t sts,
	output gsp_pkg::cmd_t      cmd
);
	import gsp_pkg::*;

	state_t state_q, state_nx;
	logic   acc;

	assign req_ready = (state_q == S_IDLE) && !sts.out_busy;
	assign acc       = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_CLEAR:     if (sts.clr_last) state_nx = S_IDLE;
			S_IDLE: begin
				if (acc) begin
					if (req_type == REQ_READ) state_nx = S_RD_WAIT;
					else if (req_type == REQ_PLAN) state_nx = S_PLAN_CHK;
				end
			end
			S_RD_WAIT:   state_nx = S_IDLE;
			S_PLAN_CHK:  state_nx = (sts.start_off || sts.goal_off) ? S_IDLE : S_VIS_CLR;
			S_VIS_CLR:   if (sts.clr_last) state_nx = S_INIT;
			S_INIT:      state_nx = S_POP;
			S_POP:       state_nx = sts.head_lt_tail ? S_POP_WAIT : S_IDLE;
			S_POP_WAIT:  state_nx = S_NBR;
			S_NBR: begin
				if (sts.cur_is_goal) state_nx = S_CNT;
				else if (sts.nbr_ok) state_nx = S_NBR_CHK;
				else if (sts.d_last) state_nx = S_POP;
			end
			S_NBR_CHK:   state_nx = sts.d_last ? S_POP : S_NBR;
			S_CNT:       state_nx = sts.cur_is_start ? S_FILL : S_CNT_WAIT;
			S_CNT_WAIT:  state_nx = S_CNT;
			S_FILL:      state_nx = sts.k_zero ? S_IDLE : S_FILL_WAIT;
			S_FILL_WAIT: state_nx = S_FILL;
			default:     state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.out_code = STS_OK;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr   = 1'b1;
				cmd.clr_free = 1'b1;
			end
			S_IDLE: begin
				if (acc) begin
					cmd.accept = 1'b1;
					unique case (req_type)
						REQ_LOAD: begin
							cmd.load_wr  = 1'b1;
							cmd.out_load = 1'b1;
						end
						REQ_PLAN: cmd.accept_plan = 1'b1;
						REQ_READ: ;
						default:  cmd.out_load = 1'b1;
					endcase
				end
			end
			S_RD_WAIT: begin
				cmd.out_load = 1'b1;
				cmd.out_read = 1'b1;
			end
			S_PLAN_CHK: begin
				if (sts.start_off) begin
					cmd.out_load = 1'b1;
					cmd.out_code = STS_OFF_GRID;
				end else if (sts.goal_off) begin
					cmd.out_load = 1'b1;
					cmd.out_code = STS_NO_PATH;
				end
			end
			S_VIS_CLR:  cmd.clr_wr = 1'b1;
			S_INIT:     cmd.init_start = 1'b1;
			S_POP: begin
				if (sts.head_lt_tail) begin
					cmd.pop_issue = 1'b1;
				end else begin
					cmd.out_load = 1'b1;
					cmd.out_code = STS_NO_PATH;
				end
			end
			S_POP_WAIT: cmd.pop_take = 1'b1;
			S_NBR: begin
				if (sts.cur_is_goal) cmd.tr_init = 1'b1;
				else if (!sts.nbr_ok && !sts.d_last) cmd.d_inc = 1'b1;
			end
			S_NBR_CHK: begin
				cmd.nbr_mark = 1'b1;
				cmd.d_inc    = !sts.d_last;
			end
			S_CNT:       if (sts.cur_is_start) cmd.fill_init = 1'b1;
			S_CNT_WAIT:  cmd.cnt_step = 1'b1;
			S_FILL: begin
				if (sts.k_zero) begin
					cmd.out_load  = 1'b1;
					cmd.set_count = 1'b1;
				end
			end
			S_FILL_WAIT: cmd.fill_step = 1'b1;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

[rtl/core/gsp_dp.sv]
// Datapath: grid memories, frontier queue, traceback and result register.
// Depends on gsp_pkg and gsp_ram; commanded by gsp_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module gsp_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire gsp_pkg::req_t                req,
	input  wire logic                         cfg_we,
	input  wire logic [gsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gsp_pkg::CFG_W-1:0]    cfg_data,
	input  wire gsp_pkg::cmd_t                cmd,
	output gsp_pkg::sts_t                     sts,
	input  wire logic                         out_ready,
	output logic                              out_valid,
	output logic [1:0]                        out_status,
	output logic [gsp_pkg::LEN_W-1:0]         out_length,
	output logic [gsp_pkg::SIDE_W-1:0]        out_x,
	output logic [gsp_pkg::SIDE_W-1:0]        out_y
);
	import gsp_pkg::*;

	logic [CFG_W-1:0]   width_q, height_q, w_eff, h_eff;
	logic [CELL_AW-1:0] clr_q, cur_q, start_q, goal_q, nbr, prev, fifo_rd, path_rd;
	logic [CELL_AW:0]   head_q, tail_q;
	logic [LEN_W-1:0]   count_q, n_q, k_q;
	logic [IDX_W-1:0]   idx_q;
	logic [1:0]         d_q, par_rd;
	logic [SIDE_W-1:0]  cx, cy;
	logic               vis_rd, free_rd, fresh, beyond, nbr_ok;
	logic               vis_we, vis_wd, free_we, free_wd, fifo_we;
	logic [CELL_AW-1:0] vis_wa, free_wa, fifo_wa, fifo_wd;
	logic               out_valid_q;

	// clamp configured sides to 1..MAX_SIDE
	assign w_eff = (width_q == '0) ? CFG_W'(1) :
		(width_q > CFG_W'(MAX_SIDE)) ? CFG_W'(MAX_SIDE) : width_q;
	assign h_eff = (height_q == '0) ? CFG_W'(1) :
		(height_q > CFG_W'(MAX_SIDE)) ? CFG_W'(MAX_SIDE) : height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(MAX_SIDE);
			height_q <= CFG_W'(MAX_SIDE);
		end else if (cfg_we) begin
			if (cfg_index == CFG_GRID_WIDTH) width_q <= cfg_data;
			if (cfg_index == CFG_GRID_HEIGHT) height_q <= cfg_data;
		end
	end

	assign cx = cur_q[SIDE_W-1:0];
	assign cy = cur_q[CELL_AW-1:SIDE_W];

	// neighbor in -x, +x, -y, +y order
	always_comb begin
		nbr = cur_q;
		nbr_ok = 1'b0;
		case (d_q)
			2'd0: begin
				nbr = {cy, cx - SIDE_W'(1)};
				nbr_ok = (cx != '0);
			end
			2'd1: begin
				nbr = {cy, cx + SIDE_W'(1)};
				nbr_ok = ({1'b0, cx} + CFG_W'(1)) < w_eff;
			end
			2'd2: begin
				nbr = {cy - SIDE_W'(1), cx};
				nbr_ok = (cy != '0);
			end
			default: begin
				nbr = {cy + SIDE_W'(1), cx};
				nbr_ok = ({1'b0, cy} + CFG_W'(1)) < h_eff;
			end
		endcase
	end

	assign sts.nbr_ok = nbr_ok;

	// step back against the recorded entry direction
	always_comb begin
		case (par_rd)
			2'd0:    prev = {cy, cx + SIDE_W'(1)};
			2'd1:    prev = {cy, cx - SIDE_W'(1)};
			2'd2:    prev = {cy + SIDE_W'(1), cx};
			default: prev = {cy - SIDE_W'(1), cx};
		endcase
	end

	assign fresh = !vis_rd && free_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.clr_wr) clr_q <= clr_q + CELL_AW'(1);
			if (cmd.accept_plan) count_q <= '0;
			if (cmd.set_count) count_q <= n_q;
			if (cmd.init_start) begin
				head_q <= '0;
				tail_q <= (CELL_AW+1)'(1);
			end
			if (cmd.pop_issue) head_q <= head_q + (CELL_AW+1)'(1);
			if (fifo_we && !cmd.init_start) tail_q <= tail_q + (CELL_AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			start_q <= {req.start_y, req.start_x};
			goal_q  <= {req.goal_y, req.goal_x};
			idx_q   <= req.step_index;
		end
		if (cmd.pop_take) begin
			cur_q <= fifo_rd;
			d_q   <= '0;
		end
		if (cmd.d_inc) d_q <= d_q + 2'd1;
		if (cmd.tr_init) begin
			cur_q <= goal_q;
			n_q   <= '0;
		end
		if (cmd.cnt_step) begin
			cur_q <= prev;
			n_q   <= n_q + LEN_W'(1);
		end
		if (cmd.fill_init) begin
			cur_q <= goal_q;
			k_q   <= n_q;
		end
		if (cmd.fill_step) begin
			cur_q <= prev;
			k_q   <= k_q - LEN_W'(1);
		end
	end

	assign sts.clr_last     = (clr_q == CELL_AW'(CELLS - 1));
	assign sts.start_off    = ({1'b0, start_q[SIDE_W-1:0]} >= w_eff) ||
		({1'b0, start_q[CELL_AW-1:SIDE_W]} >= h_eff);
	assign sts.goal_off     = ({1'b0, goal_q[SIDE_W-1:0]} >= w_eff) ||
		({1'b0, goal_q[CELL_AW-1:SIDE_W]} >= h_eff);
	assign sts.head_lt_tail = head_q < tail_q;
	assign sts.cur_is_goal  = cur_q == goal_q;
	assign sts.cur_is_start = cur_q == start_q;
	assign sts.d_last       = d_q == 2'd3;
	assign sts.k_zero       = k_q == '0;
	assign sts.out_busy     = out_valid_q && !out_ready;

	// memory write ports
	always_comb begin
		vis_we  = 1'b0; vis_wa  = clr_q; vis_wd = 1'b0;
		free_we = 1'b0; free_wa = clr_q; free_wd = 1'b0;
		fifo_we = 1'b0; fifo_wa = tail_q[CELL_AW-1:0]; fifo_wd = nbr;
		if (cmd.clr_wr) begin
			vis_we  = 1'b1;
			free_we = cmd.clr_free;
		end else if (cmd.init_start) begin
			vis_we  = 1'b1; vis_wa = start_q; vis_wd = 1'b1;
			fifo_we = 1'b1; fifo_wa = '0; fifo_wd = start_q;
		end else if (cmd.nbr_mark && fresh) begin
			vis_we  = 1'b1; vis_wa = nbr; vis_wd = 1'b1;
			fifo_we = !tail_q[CELL_AW];
		end
		if (cmd.load_wr) begin
			free_we = 1'b1;
			free_wa = {req.cell_y, req.cell_x};
			free_wd = req.cell_free;
		end
	end

	gsp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_free (
		.clk(clk), .we(free_we), .waddr(free_wa), .wdata(free_wd),
		.raddr(nbr), .rdata(free_rd));

	gsp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
		.clk(clk), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd),
		.raddr(nbr), .rdata(vis_rd));

	gsp_ram #(.WIDTH(2), .DEPTH(CELLS)) u_parent (
		.clk(clk), .we(cmd.nbr_mark && fresh), .waddr(nbr), .wdata(d_q),
		.raddr(cur_q), .rdata(par_rd));

	gsp_ram #(.WIDTH(CELL_AW), .DEPTH(CELLS)) u_fifo (
		.clk(clk), .we(fifo_we), .waddr(fifo_wa), .wdata(fifo_wd),
		.raddr(head_q[CELL_AW-1:0]), .rdata(fifo_rd));

	gsp_ram #(.WIDTH(CELL_AW), .DEPTH(CELLS)) u_path (
		.clk(clk), .we(cmd.fill_step), .waddr(CELL_AW'(k_q - LEN_W'(1))), .wdata(cur_q),
		.raddr(CELL_AW'(req.step_index)), .rdata(path_rd));

	assign beyond = idx_q >= count_q;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status <= cmd.out_read ? (beyond ? STS_BEYOND : STS_OK) : cmd.out_code;
			out_length <= cmd.set_count ? n_q : count_q;
			if (cmd.out_read && !beyond) begin
				out_x <= path_rd[SIDE_W-1:0];
				out_y <= path_rd[CELL_AW-1:SIDE_W];
			end else begin
				out_x <= '0;
				out_y <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

[rtl/core/grid_shortest_path_search_top.sv]
// Top level of the grid shortest-path search block.
// Depends on gsp_pkg, gsp_if, gsp_ctrl, gsp_dp (and gsp_ram below it).
//
//  channel  dir  handshake          payload
//  req      in   valid/ready        req_type, cell_x/y, cell_free, start_x/y, goal_x/y, step_index
//  rsp      out  valid/ready        status, path_length, step_x, step_y
//  cfg      in   cfg_we             cfg_index, cfg_data (grid_width, grid_height)
//
// Load and no-op results load on accept; a read first waits in S_RD_WAIT for the path RAM.
// A plan: check, visited clear over all 4096 cells, seed, then per popped cell S_POP and
// S_POP_WAIT, S_NBR per direction plus S_NBR_CHK if in grid, then count and fill per path step.
// After reset the map and visited RAMs are swept over all cells before req.ready rises.
// One transaction is in work at a time; rsp is registered, so a stalled sink
// only holds off the next request until the result slot frees.
`timescale 1ns / 1ps
`default_nettype none
module grid_shortest_path_search_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	gsp_req_if.sink                            req,
	gsp_rsp_if.source                          rsp,
	input  wire logic                          cfg_we,
	input  wire logic [gsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gsp_pkg::CFG_W-1:0]     cfg_data
);
	import gsp_pkg::*;

	req_t req_bus;
	cmd_t cmd;
	sts_t sts;

	// flatten the request payload for the datapath
	assign req_bus.req_type   = req.req_type;
	assign req_bus.cell_x     = req.cell_x;
	assign req_bus.cell_y     = req.cell_y;
	assign req_bus.cell_free  = req.cell_free;
	assign req_bus.start_x    = req.start_x;
	assign req_bus.start_y    = req.start_y;
	assign req_bus.goal_x     = req.goal_x;
	assign req_bus.goal_y     = req.goal_y;
	assign req_bus.step_index = req.step_index;

	gsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gsp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_bus),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.out_status (rsp.status),
		.out_length (rsp.path_length),
		.out_x      (rsp.step_x),
		.out_y      (rsp.step_y)
	);
endmodule
`default_nettype wire

[rtl/core/gsp_checker.sv]
// Port-level assertions for the grid shortest-path search top, with bind.
// Depends on gsp_pkg and grid_shortest_path_search_top.
`timescale 1ns / 1ps
`default_nettype none
module gsp_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic [1:0]                 in_type,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic [1:0]                 out_status,
	input wire logic [gsp_pkg::LEN_W-1:0]  out_length,
	input wire logic [gsp_pkg::SIDE_W-1:0] out_x,
	input wire logic [gsp_pkg::SIDE_W-1:0] out_y
);
	import gsp_pkg::*;

	// a pending result is never dropped
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a map load answers in the next cycle
	a_load_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_type == REQ_LOAD |=> out_valid)
		else $error("load result late");

	// failed plans leave no path
	a_fail_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status == STS_NO_PATH || out_status == STS_OFF_GRID)
		|-> out_length == '0)
		else $error("failed plan reports a length");

	// out-of-range reads carry no cell
	a_beyond: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == STS_BEYOND |-> out_x == '0 && out_y == '0)
		else $error("beyond-path read carries a cell");
endmodule

bind grid_shortest_path_search_top gsp_checker u_gsp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.in_type    (req.req_type),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.out_status (rsp.status),
	.out_length (rsp.path_length),
	.out_x      (rsp.step_x),
	.out_y      (rsp.step_y)
);
`default_nettype wire
